// ===== design/tgct_pkg.sv =====
// Package: shared types, constants and helpers for the two-target center tracker.
package tgct_pkg;

    localparam int TRACK_DEPTH_DEF  = 20;
    localparam int CENTER_DEPTH_DEF = 5;
    localparam int RANGE_DEPTH_DEF  = 30;

    localparam logic [2:0] CFG_FAR      = 3'd0;
    localparam logic [2:0] CFG_PERSIST  = 3'd1;
    localparam logic [2:0] CFG_APPROACH = 3'd2;
    localparam logic [2:0] CFG_BOX      = 3'd3;
    localparam logic [2:0] CFG_PROX     = 3'd4;

    localparam logic [1:0] SEL_NONE = 2'd0;
    localparam logic [1:0] SEL_RED  = 2'd1;
    localparam logic [1:0] SEL_BLUE = 2'd2;

    typedef struct packed {
        logic               opcode;
        logic               color_given;
        logic [7:0]         red_level;
        logic [7:0]         blue_level;
        logic signed [15:0] x_pos;
        logic signed [15:0] y_pos;
        logic               last_point;
    } t_in_word;

    typedef struct packed {
        logic               report_valid;
        logic               moving_color;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
    } t_out_word;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_point;

    // squared distance of two points, exact in 34 bits
    function automatic logic [33:0] dist2(input t_point a, input t_point b);
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic signed [33:0] wx;
        logic signed [33:0] wy;
        dx = 17'(a.x) - 17'(b.x);
        dy = 17'(a.y) - 17'(b.y);
        wx = 34'(dx);
        wy = 34'(dy);
        dist2 = 34'(unsigned'(wx * wx)) + 34'(unsigned'(wy * wy));
    endfunction

endpackage

// ===== design/tgct_track_cell.sv =====
// Trajectory cell: one stored point, near-test and shift to the neighbor.
module tgct_track_cell
    import tgct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_load,
    input  t_point      i_pt,
    input  t_point      i_probe,
    input  logic [33:0] i_lim,
    output t_point      o_pt,
    output logic        o_near
);
    t_point r_pt;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pt <= i_pt;
        end
    end

    assign o_pt   = r_pt;
    assign o_near = (dist2(i_probe, r_pt) <= i_lim);
endmodule

// ===== design/tgct_sqrt.sv =====
// Iterative integer square root, one result bit per cycle.
module tgct_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [33:0] i_val,
    output logic        o_busy,
    output logic [16:0] o_root
);
    logic [33:0] r_rem;
    logic [35:0] r_root;
    logic [35:0] r_bit;
    logic        r_busy;
    logic [35:0] w_sum;
    logic [35:0] w_rem;

    always_comb begin
        w_rem = 36'(r_rem);
        w_sum = r_root + r_bit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_rem  <= i_val;
            r_root <= '0;
            r_bit  <= 36'h4_0000_0000 >> 2;
        end else if (r_busy) begin
            if (w_rem >= w_sum) begin
                r_rem  <= 34'(w_rem - w_sum);
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
            if (r_bit == 36'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root[16:0];
endmodule

// ===== design/two_target_gated_center_tracker.sv =====
// Top level: two-color gated center tracker with range trend selection.
// A point word that does not end a message holds the input through acceptance and the gate
// state over the row of trajectory cells, which all compare in parallel. A last point adds,
// for each color holding a center, a 17-step square root with its handoff states (a color
// without a center is skipped), then the select state and the output state. A clusters word
// goes from acceptance straight to the output state. One word is in work at a time; a
// finished output word sits in a register while the next input word is taken, and a stalled
// output holds the block only once the next output word is ready.
module two_target_gated_center_tracker
    import tgct_pkg::*;
#(
    parameter int TRACK_DEPTH  = TRACK_DEPTH_DEF,
    parameter int CENTER_DEPTH = CENTER_DEPTH_DEF,
    parameter int RANGE_DEPTH  = RANGE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int TW = $clog2(TRACK_DEPTH + 1);
    localparam int CW = $clog2(CENTER_DEPTH + 1);
    localparam int RW = $clog2(RANGE_DEPTH + 1);
    localparam int RI = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_GATE  = 3'd1;
    localparam logic [2:0] ST_SQ0   = 3'd2;
    localparam logic [2:0] ST_SQ1   = 3'd3;
    localparam logic [2:0] ST_SEL   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;
    localparam logic [2:0] ST_SQW   = 3'd6;

    logic [14:0] r_far;
    logic [7:0]  r_persist;
    logic [15:0] r_appr;
    logic [15:0] r_box;
    logic [15:0] r_prox;

    logic [2:0]  r_st;
    logic        r_color;
    t_point      r_pt;
    logic        r_last;
    logic        r_sqc;

    logic [TW-1:0] r_tcnt [2];
    logic [7:0]    r_farc [2];
    logic [1:0]    r_cval;
    t_point        r_cnow [2];
    t_point        r_chist [2][CENTER_DEPTH];
    logic [CW-1:0] r_ccnt [2];
    logic [15:0]   r_rhist [2][RANGE_DEPTH];
    logic [15:0]   r_rnew [2];
    logic [RW-1:0] r_rcnt [2];
    logic [1:0]    r_sel;
    logic          r_clus;

    logic          r_ovalid;
    t_out_word     r_odata;

    t_point        w_tpt  [2][TRACK_DEPTH];
    logic          w_near [2][TRACK_DEPTH];
    logic [1:0]    w_shift;
    logic [1:0]    w_clear;
    logic [33:0]   w_lim;

    logic          w_sq_start;
    logic          w_sq_busy;
    logic [16:0]   w_sq_root;

    assign w_lim = 34'(r_far) * 34'(r_far);

    genvar gc, gi;
    generate
        for (gc = 0; gc < 2; gc++) begin : g_color
            for (gi = 0; gi < TRACK_DEPTH; gi++) begin : g_cell
                t_point w_in;
                logic   w_ld;
                // cell i loads the new point at the write slot or from its right neighbor
                always_comb begin
                    w_ld = 1'b0;
                    w_in = r_pt;
                    if (w_shift[gc]) begin
                        if (w_clear[gc]) begin
                            w_ld = (gi == 0);
                        end else if (r_tcnt[gc] >= TW'(TRACK_DEPTH)) begin
                            w_ld = 1'b1;
                            if (gi < TRACK_DEPTH - 1) begin
                                w_in = w_tpt[gc][(gi + 1) % TRACK_DEPTH];
                            end
                        end else begin
                            w_ld = (r_tcnt[gc] == TW'(gi));
                        end
                    end
                end
                tgct_track_cell u_cell (
                    .i_clk  (i_clk),
                    .i_load (w_ld),
                    .i_pt   (w_in),
                    .i_probe(r_pt),
                    .i_lim  (w_lim),
                    .o_pt   (w_tpt[gc][gi]),
                    .o_near (w_near[gc][gi])
                );
            end
        end
    endgenerate

    logic w_anynear;
    logic w_empty;
    logic [7:0] w_farinc;
    logic w_accept;
    logic w_restart;
    always_comb begin
        w_anynear = 1'b0;
        for (int i = 0; i < TRACK_DEPTH; i++) begin
            if (TW'(i) < r_tcnt[r_color] && w_near[r_color][i]) begin
                w_anynear = 1'b1;
            end
        end
        w_empty   = (r_tcnt[r_color] == '0);
        w_farinc  = r_farc[r_color] + 8'd1;
        w_restart = !w_empty && !w_anynear && (w_farinc >= r_persist);
        w_accept  = w_empty || w_anynear || w_restart;
        w_shift   = '0;
        w_clear   = '0;
        if (r_st == ST_GATE && w_accept) begin
            w_shift[r_color] = 1'b1;
            w_clear[r_color] = w_restart;
        end
    end

    // square root feed
    assign w_sq_start = (r_st == ST_SQ0 || r_st == ST_SQ1) && !w_sq_busy;
    tgct_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_sq_start && r_cval[r_sqc]),
        .i_val  (dist2(r_cnow[r_sqc], '0)),
        .o_busy (w_sq_busy),
        .o_root (w_sq_root)
    );

    // report logic
    function automatic logic signed [17:0] f_trend(input int c_i, input logic [RW-1:0] cnt,
                                                  input logic [15:0] newest,
                                                  input logic [15:0] oldest);
        f_trend = (cnt < RW'(2)) ? 18'sd0 : (signed'(18'(newest)) - signed'(18'(oldest)));
        if (c_i < 0) f_trend = '0;
    endfunction

    logic signed [17:0] w_tr0, w_tr1;
    always_comb begin
        w_tr0 = f_trend(0, r_rcnt[0], r_rnew[0], r_rhist[0][0]);
        w_tr1 = f_trend(1, r_rcnt[1], r_rnew[1], r_rhist[1][0]);
    end

    logic        w_mc;
    logic        w_inbox;
    logic        w_close;
    logic        w_ok;
    logic signed [16:0] w_mnx, w_mxx, w_mny, w_mxy;
    always_comb begin
        w_mc = (r_sel == SEL_BLUE);
        w_mnx = 17'(r_chist[w_mc][0].x);
        w_mxx = w_mnx;
        w_mny = 17'(r_chist[w_mc][0].y);
        w_mxy = w_mny;
        for (int i = 1; i < CENTER_DEPTH; i++) begin
            if (17'(r_chist[w_mc][i].x) < w_mnx) w_mnx = 17'(r_chist[w_mc][i].x);
            if (17'(r_chist[w_mc][i].x) > w_mxx) w_mxx = 17'(r_chist[w_mc][i].x);
            if (17'(r_chist[w_mc][i].y) < w_mny) w_mny = 17'(r_chist[w_mc][i].y);
            if (17'(r_chist[w_mc][i].y) > w_mxy) w_mxy = 17'(r_chist[w_mc][i].y);
        end
        w_inbox = (r_ccnt[w_mc] < CW'(CENTER_DEPTH)) ||
                  !((17'(w_mxx - w_mnx) > 17'(r_box)) || (17'(w_mxy - w_mny) > 17'(r_box)));
        w_close = r_cval[0] && r_cval[1] &&
                  (dist2(r_cnow[0], r_cnow[1]) < 34'(r_prox) * 34'(r_prox));
        w_ok = (r_sel != SEL_NONE) && w_inbox && !w_close && r_clus && r_cval[w_mc];
    end

    assign o_stall     = (r_st != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_data      = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_far <= 15'd300; r_persist <= 8'd20; r_appr <= 16'd10;
            r_box <= 16'd300; r_prox <= 16'd200;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FAR:      r_far     <= i_cfg_data[14:0];
                CFG_PERSIST:  r_persist <= i_cfg_data[7:0];
                CFG_APPROACH: r_appr    <= i_cfg_data;
                CFG_BOX:      r_box     <= i_cfg_data;
                CFG_PROX:     r_prox    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_sel <= SEL_NONE;
            r_clus <= 1'b0;
            r_cval <= '0;
            r_sqc <= 1'b0;
            for (int c = 0; c < 2; c++) begin
                r_tcnt[c] <= '0; r_farc[c] <= '0; r_ccnt[c] <= '0; r_rcnt[c] <= '0;
                r_cnow[c] <= '0;
            end
        end else begin
            if (r_ovalid && !i_stall && r_st != ST_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                ST_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_pt.x  <= i_data.x_pos;
                        r_pt.y  <= i_data.y_pos;
                        r_last  <= i_data.last_point;
                        r_color <= i_data.color_given && (i_data.red_level < i_data.blue_level);
                        if (i_data.opcode) begin
                            r_clus <= 1'b1;
                            r_st   <= ST_OUT;
                        end else begin
                            r_st <= ST_GATE;
                        end
                    end
                end
                ST_GATE: begin
                    if (w_accept) begin
                        r_farc[r_color] <= '0;
                        if (w_restart) r_tcnt[r_color] <= TW'(1);
                        else if (r_tcnt[r_color] < TW'(TRACK_DEPTH))
                            r_tcnt[r_color] <= r_tcnt[r_color] + TW'(1);
                        r_cnow[r_color] <= r_pt;
                        r_cval[r_color] <= 1'b1;
                        if (r_ccnt[r_color] >= CW'(CENTER_DEPTH)) begin
                            for (int i = 0; i < CENTER_DEPTH - 1; i++)
                                r_chist[r_color][i] <= r_chist[r_color][i + 1];
                            r_chist[r_color][CENTER_DEPTH - 1] <= r_pt;
                        end else begin
                            r_chist[r_color][r_ccnt[r_color]] <= r_pt;
                            r_ccnt[r_color] <= r_ccnt[r_color] + CW'(1);
                        end
                    end else begin
                        r_farc[r_color] <= w_farinc;
                    end
                    r_sqc <= 1'b0;
                    r_st  <= r_last ? ST_SQ0 : ST_IDLE;
                end
                ST_SQ0, ST_SQ1: begin
                    if (!w_sq_busy) begin
                        if (r_cval[r_sqc]) r_st <= ST_SQW;
                        else if (r_st == ST_SQ0) begin
                            r_sqc <= 1'b1; r_st <= ST_SQ1;
                        end else r_st <= ST_SEL;
                    end
                end
                ST_SQW: begin
                    if (!w_sq_busy) begin
                        r_rnew[r_sqc] <= w_sq_root[15:0];
                        if (r_rcnt[r_sqc] >= RW'(RANGE_DEPTH)) begin
                            for (int i = 0; i < RANGE_DEPTH - 1; i++)
                                r_rhist[r_sqc][i] <= r_rhist[r_sqc][i + 1];
                            r_rhist[r_sqc][RANGE_DEPTH - 1] <= w_sq_root[15:0];
                        end else begin
                            r_rhist[r_sqc][RI'(r_rcnt[r_sqc])] <= w_sq_root[15:0];
                            r_rcnt[r_sqc] <= r_rcnt[r_sqc] + RW'(1);
                        end
                        if (r_sqc) r_st <= ST_SEL;
                        else begin
                            r_sqc <= 1'b1; r_st <= ST_SQ1;
                        end
                    end
                end
                ST_SEL: begin
                    if (w_tr0 < -signed'(18'(r_appr))) r_sel <= SEL_RED;
                    else if (w_tr1 > signed'(18'(r_appr))) r_sel <= SEL_BLUE;
                    r_st <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_odata.report_valid <= w_ok;
                        r_odata.moving_color <= w_mc;
                        r_odata.center_x <= w_ok ? r_cnow[w_mc].x : 16'sd0;
                        r_odata.center_y <= w_ok ? r_cnow[w_mc].y : 16'sd0;
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_IDLE) |-> o_stall) else $error("input taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("output dropped");
    a_zero_when_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.report_valid) |-> (o_data.center_x == 16'sd0))
        else $error("unreported center nonzero");
endmodule

// ===== bench/tb.sv =====
// Testbench for the two-target gated center tracker: random and directed words checked against a predictor.
`timescale 1ns / 100ps

class tracker_scoreboard;
    logic [14:0] far_thr;
    logic [7:0]  persist;
    logic [15:0] approach;
    logic [15:0] box_lim;
    logic [15:0] prox_lim;

    int          trk_x[2][$];
    int          trk_y[2][$];
    int          far_cnt[2];
    bit          cur_ok[2];
    int          cur_x[2];
    int          cur_y[2];
    int          hist_x[2][$];
    int          hist_y[2][$];
    int          rng[2][$];
    logic [1:0]  sel;
    bit          clusters;

    tgct_pkg::t_out_word expected_words[$];
    int          errors;

    function new();
        far_thr = 300;
        persist = 20;
        approach = 10;
        box_lim = 300;
        prox_lim = 200;
        for (int c = 0; c < 2; c++) begin
            far_cnt[c] = 0;
            cur_ok[c] = 0;
            cur_x[c] = 0;
            cur_y[c] = 0;
        end
        sel = tgct_pkg::SEL_NONE;
        clusters = 0;
        errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            tgct_pkg::CFG_FAR:      far_thr = val[14:0];
            tgct_pkg::CFG_PERSIST:  persist = val[7:0];
            tgct_pkg::CFG_APPROACH: approach = val;
            tgct_pkg::CFG_BOX:      box_lim = val;
            tgct_pkg::CFG_PROX:     prox_lim = val;
            default: ;
        endcase
    endfunction

    function longint sq_dist(int ax, int ay, int bx, int by);
        longint dx;
        longint dy;
        dx = ax - bx;
        dy = ay - by;
        return dx * dx + dy * dy;
    endfunction

    function int root_floor(longint v);
        longint r;
        r = 0;
        for (int b = 16; b >= 0; b--)
            if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= v)
                r = r + (64'd1 << b);
        return int'(r);
    endfunction

    function void trk_add(int c, int x, int y);
        if (trk_x[c].size() >= tgct_pkg::TRACK_DEPTH_DEF) begin
            trk_x[c].delete(0);
            trk_y[c].delete(0);
        end
        trk_x[c].insert(trk_x[c].size(), x);
        trk_y[c].insert(trk_y[c].size(), y);
    endfunction

    function bit gate_point(int c, int x, int y);
        longint lim;
        bit near;
        lim = longint'(far_thr) * far_thr;
        near = 0;
        if (trk_x[c].size() == 0) begin
            trk_add(c, x, y);
            far_cnt[c] = 0;
            return 1;
        end
        foreach (trk_x[c][i])
            if (sq_dist(x, y, trk_x[c][i], trk_y[c][i]) <= lim) near = 1;
        if (near) begin
            trk_add(c, x, y);
            far_cnt[c] = 0;
            return 1;
        end
        far_cnt[c] = (far_cnt[c] + 1) & 255;
        if (far_cnt[c] >= persist) begin
            trk_x[c].delete();
            trk_y[c].delete();
            trk_add(c, x, y);
            far_cnt[c] = 0;
            return 1;
        end
        return 0;
    endfunction

    function int trend_of(int c);
        if (rng[c].size() < 2) return 0;
        return rng[c][$] - rng[c][0];
    endfunction

    function bit box_ok(int c);
        int mnx;
        int mxx;
        int mny;
        int mxy;
        if (hist_x[c].size() < tgct_pkg::CENTER_DEPTH_DEF) return 1;
        mnx = hist_x[c][0];
        mxx = mnx;
        mny = hist_y[c][0];
        mxy = mny;
        for (int i = 1; i < hist_x[c].size(); i++) begin
            if (hist_x[c][i] < mnx) mnx = hist_x[c][i];
            if (hist_x[c][i] > mxx) mxx = hist_x[c][i];
            if (hist_y[c][i] < mny) mny = hist_y[c][i];
            if (hist_y[c][i] > mxy) mxy = hist_y[c][i];
        end
        return !((mxx - mnx) > box_lim || (mxy - mny) > box_lim);
    endfunction

    function void push_report();
        int c;
        bit close;
        bit ok;
        tgct_pkg::t_out_word w;
        c = (sel == tgct_pkg::SEL_BLUE) ? 1 : 0;
        close = cur_ok[0] && cur_ok[1] &&
            sq_dist(cur_x[0], cur_y[0], cur_x[1], cur_y[1]) < longint'(prox_lim) * prox_lim;
        ok = sel != tgct_pkg::SEL_NONE && box_ok(c) && !close && clusters && cur_ok[c];
        w.report_valid = ok;
        w.moving_color = c[0];
        w.center_x = ok ? 16'(cur_x[c]) : 16'sd0;
        w.center_y = ok ? 16'(cur_y[c]) : 16'sd0;
        expected_words.insert(expected_words.size(), w);
    endfunction

    function void note_input(tgct_pkg::t_in_word w);
        int c;
        int x;
        int y;
        if (w.opcode) begin
            clusters = 1;
            push_report();
            return;
        end
        c = (w.color_given && w.red_level < w.blue_level) ? 1 : 0;
        x = w.x_pos;
        y = w.y_pos;
        if (gate_point(c, x, y)) begin
            cur_x[c] = x;
            cur_y[c] = y;
            cur_ok[c] = 1;
            if (hist_x[c].size() >= tgct_pkg::CENTER_DEPTH_DEF) begin
                hist_x[c].delete(0);
                hist_y[c].delete(0);
            end
            hist_x[c].insert(hist_x[c].size(), x);
            hist_y[c].insert(hist_y[c].size(), y);
        end
        if (!w.last_point) return;
        for (int k = 0; k < 2; k++) begin
            if (cur_ok[k]) begin
                if (rng[k].size() >= tgct_pkg::RANGE_DEPTH_DEF) rng[k].delete(0);
                rng[k].insert(rng[k].size(), root_floor(sq_dist(cur_x[k], cur_y[k], 0, 0)));
            end
        end
        if (trend_of(0) < -int'(approach)) sel = tgct_pkg::SEL_RED;
        else if (trend_of(1) > int'(approach)) sel = tgct_pkg::SEL_BLUE;
        push_report();
    endfunction

    function void check_result(tgct_pkg::t_out_word got);
        tgct_pkg::t_out_word e;
        if (expected_words.size() == 0) begin
            $error("unexpected output word %h", got);
            errors++;
            return;
        end
        e = expected_words[0];
        expected_words.delete(0);
        if (got.report_valid !== e.report_valid) begin
            $error("report_valid expected %0d actual %0d", e.report_valid, got.report_valid);
            errors++;
        end
        if (got.moving_color !== e.moving_color) begin
            $error("moving_color expected %0d actual %0d", e.moving_color, got.moving_color);
            errors++;
        end
        if (got.center_x !== e.center_x) begin
            $error("center_x expected %0d actual %0d", e.center_x, got.center_x);
            errors++;
        end
        if (got.center_y !== e.center_y) begin
            $error("center_y expected %0d actual %0d", e.center_y, got.center_y);
            errors++;
        end
    endfunction
endclass

module tb;
    import tgct_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_word    in_word;
    logic        out_valid;
    logic        out_stall;
    t_out_word   out_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    tracker_scoreboard sb;
    longint      cycles = 0;
    bit          hold_long;
    int          base_x;
    int          base_y;
    int          out_wait;
    int          out_draw;

    two_target_gated_center_tracker uut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_valid(in_valid),
        .o_stall(in_stall),
        .i_data(in_word),
        .o_valid(out_valid),
        .i_stall(out_stall),
        .o_data(out_word),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_result(out_word);
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 0;
            out_wait <= 0;
        end else if (hold_long) begin
            out_stall <= 1;
        end else if (out_valid && !out_stall) begin
            out_draw = $urandom_range(0, 10);
            out_wait <= out_draw;
            out_stall <= (out_draw > 0);
        end else if (out_wait > 1) begin
            out_wait <= out_wait - 1;
        end else begin
            out_wait <= 0;
            out_stall <= 0;
        end
    end

    task automatic send_word(t_in_word w, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_word <= w;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(w);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, val);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.expected_words.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic t_in_word point_word(bit blue, int x, int y, bit last_pt);
        t_in_word w;
        w.opcode = 0;
        w.color_given = 1'($urandom_range(0, 1));
        w.red_level = 8'($urandom);
        w.blue_level = 8'($urandom);
        if (blue) begin
            w.color_given = 1;
            if (w.red_level >= w.blue_level) begin
                w.red_level = 8'($urandom_range(0, 254));
                w.blue_level = 8'($urandom_range(w.red_level + 1, 255));
            end
        end else if (w.color_given && w.red_level < w.blue_level) begin
            w.red_level = w.blue_level;
        end
        w.x_pos = 16'(x);
        w.y_pos = 16'(y);
        w.last_point = last_pt;
        return w;
    endfunction

    function automatic t_in_word random_word();
        logic [63:0] rnd;
        t_in_word w;
        rnd = {$urandom, $urandom};
        w = rnd[$bits(t_in_word)-1:0];
        return w;
    endfunction

    function automatic t_in_word clusters_word();
        t_in_word w;
        w = random_word();
        w.opcode = 1;
        return w;
    endfunction

    function automatic int clip16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    task automatic random_messages(int n_words, int step);
        int sent;
        int npts;
        int bx;
        int by;
        t_in_word w;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(clusters_word(), 1);
                sent++;
            end else if ($urandom_range(0, 14) == 0) begin
                w = random_word();
                w.opcode = 0;
                send_word(w, 1);
                sent++;
            end else begin
                npts = $urandom_range(1, 3);
                base_x = clip16(base_x + $urandom_range(0, 2 * step) - step);
                base_y = clip16(base_y + $urandom_range(0, 2 * step) - step);
                for (int p = 0; p < npts; p++) begin
                    bx = clip16(base_x + (p % 2 ? 900 : 0) + $urandom_range(0, 40) - 20);
                    by = clip16(base_y + $urandom_range(0, 40) - 20);
                    send_word(point_word(1'(p % 2), bx, by, p == npts - 1), 1);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        t_in_word w;
        sb = new();
        rst_n = 0;
        in_valid = 0;
        in_word = '0;
        cfg_valid = 0;
        cfg_index = CFG_FAR;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_word(clusters_word(), 0);
        send_word(point_word(0, 0, 0, 1), 0);
        send_word(point_word(1, 32767, 32767, 0), 0);
        send_word(point_word(0, -32768, -32768, 1), 0);
        send_word(point_word(1, -32768, 32767, 1), 0);
        w = point_word(0, 100, 100, 1);
        w.color_given = 0;
        w.red_level = 8'h00;
        w.blue_level = 8'hFF;
        send_word(w, 0);
        w.color_given = 1;
        w.red_level = 8'h80;
        w.blue_level = 8'h80;
        w.x_pos = 16'sd120;
        send_word(w, 0);
        for (int k = 0; k < 6; k++) begin
            send_word(point_word(0, 3000 - 400 * k, 50 * k, 0), 0);
            send_word(point_word(1, 2000 + 500 * k, -50 * k, 1), 0);
        end
        send_word(clusters_word(), 0);
        drain();

        write_reg(CFG_FAR, 16'h7FFF);
        write_reg(CFG_PERSIST, 16'd1);
        write_reg(CFG_APPROACH, 16'd0);
        write_reg(CFG_BOX, 16'hFFFF);
        write_reg(CFG_PROX, 16'd0);
        base_x = 0;
        base_y = 0;
        random_messages(110, 3000);
        drain();

        write_reg(CFG_FAR, 16'd0);
        write_reg(CFG_PERSIST, 16'd0);
        write_reg(CFG_APPROACH, 16'hFFFF);
        write_reg(CFG_BOX, 16'd0);
        write_reg(CFG_PROX, 16'hFFFF);
        random_messages(60, 200);
        drain();

        write_reg(CFG_FAR, 16'd300);
        write_reg(CFG_PERSIST, 16'd255);
        write_reg(CFG_APPROACH, 16'd10);
        write_reg(CFG_BOX, 16'd300);
        write_reg(CFG_PROX, 16'd200);
        base_x = 1000;
        base_y = -1000;
        fork
            begin
                hold_long <= 1;
                repeat (400) @(posedge clk);
                hold_long <= 0;
            end
            random_messages(40, 60);
        join
        drain();

        write_reg(CFG_FAR, 16'd500);
        write_reg(CFG_PERSIST, 16'd4);
        write_reg(CFG_APPROACH, 16'd5);
        write_reg(CFG_BOX, 16'd2000);
        write_reg(CFG_PROX, 16'd100);
        random_messages(220, 150);
        drain();

        if (sb.errors == 0 && sb.expected_words.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
design/tgct_pkg.sv
design/tgct_track_cell.sv
design/tgct_sqrt.sv
design/two_target_gated_center_tracker.sv
bench/tb.sv
